[hw/rtl/mascon_pkg.sv]
// shared types, constants and round function of the masked ascon permutation
package mascon_pkg;

  localparam int unsigned NumRounds = 12;
  localparam int unsigned RoundW    = 4;
  localparam logic [RoundW-1:0] RcBase    = 4'hF;
  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds);

  typedef logic [63:0] word_t;

  typedef struct packed {
    word_t            share_a_word0;
    word_t            share_a_word1;
    word_t            share_a_word2;
    word_t            share_a_word3;
    word_t            share_a_word4;
    word_t            share_b_word0;
    word_t            share_b_word1;
    word_t            share_b_word2;
    word_t            share_b_word3;
    word_t            share_b_word4;
    logic [RoundW-1:0] start_round;
    word_t            random_mask;
  } mascon_in_t;

  typedef struct packed {
    word_t out_a_word0;
    word_t out_a_word1;
    word_t out_a_word2;
    word_t out_a_word3;
    word_t out_a_word4;
    word_t out_b_word0;
    word_t out_b_word1;
    word_t out_b_word2;
    word_t out_b_word3;
    word_t out_b_word4;
  } mascon_out_t;

  // working state: both shares and the running mask word
  typedef struct packed {
    word_t [4:0] a;
    word_t [4:0] b;
    word_t       t;
  } mascon_st_t;

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic word_t [4:0] diffuse(word_t [4:0] w);
    word_t [4:0] o;
    o[0] = w[0] ^ rotr(w[0], 19) ^ rotr(w[0], 28);
    o[1] = w[1] ^ rotr(w[1], 61) ^ rotr(w[1], 39);
    o[2] = w[2] ^ rotr(w[2], 1)  ^ rotr(w[2], 6);
    o[3] = w[3] ^ rotr(w[3], 10) ^ rotr(w[3], 17);
    o[4] = w[4] ^ rotr(w[4], 7)  ^ rotr(w[4], 41);
    return o;
  endfunction

  // one full masked round
  function automatic mascon_st_t mascon_round(mascon_st_t s, logic [RoundW-1:0] r);
    word_t [4:0] a;
    word_t [4:0] b;
    word_t [4:0] na;
    word_t [4:0] nb;
    word_t       ta;
    word_t       tb;
    mascon_st_t  o;
    a = s.a;
    b = s.b;
    a[2] = a[2] ^ {56'd0, RcBase - r, r};
    a[0] = a[0] ^ a[4];
    a[4] = a[4] ^ a[3];
    a[2] = a[2] ^ a[1];
    b[0] = b[0] ^ b[4];
    b[4] = b[4] ^ b[3];
    b[2] = b[2] ^ b[1];
    // cross-share terms, and-not on share a and plain and on share b, all on the words after the input xors
    ta    = s.t ^ (~a[0] & b[1]) ^ (~a[0] & a[1]);
    tb    = s.t ^ (b[0] & b[1]) ^ (b[0] & a[1]);
    na[0] = a[0] ^ (~a[1] & b[2]) ^ (~a[1] & a[2]);
    nb[0] = b[0] ^ (b[1] & b[2]) ^ (b[1] & a[2]);
    na[1] = a[1] ^ (~a[2] & b[3]) ^ (~a[2] & a[3]);
    nb[1] = b[1] ^ (b[2] & b[3]) ^ (b[2] & a[3]);
    na[2] = a[2] ^ (~a[3] & b[4]) ^ (~a[3] & a[4]);
    nb[2] = b[2] ^ (b[3] & b[4]) ^ (b[3] & a[4]);
    na[3] = a[3] ^ (~a[4] & b[0]) ^ (~a[4] & a[0]);
    nb[3] = b[3] ^ (b[4] & b[0]) ^ (b[4] & a[0]);
    na[4] = a[4] ^ ta;
    nb[4] = b[4] ^ tb;
    na[1] = na[1] ^ na[0];
    na[0] = na[0] ^ na[4];
    na[3] = na[3] ^ na[2];
    na[2] = ~na[2];
    nb[1] = nb[1] ^ nb[0];
    nb[0] = nb[0] ^ nb[4];
    nb[3] = nb[3] ^ nb[2];
    o.a = diffuse(na);
    o.b = diffuse(nb);
    o.t = ta;
    return o;
  endfunction

endpackage

[hw/rtl/masked_ascon_permutation.sv]
// top level: two-share masked ascon permutation, one round per cycle
//
//   channel | ports               | handshake
//   --------+---------------------+-------------------------------------
//   in      | in_i                | start, taken when start && !busy
//   out     | res_o               | done_o, one cycle, cannot be held off
//
// a word starting at round s runs rounds s through 11 on the shared round unit,
// then its result is registered; for s >= 12 no round runs. busy stays high
// from the accepting edge until the result is registered; done_o pulses for
// one cycle and the next word may be taken in that same cycle. reset clears
// the sequencer and the strobe only.
module masked_ascon_permutation (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  mascon_pkg::mascon_in_t  in_i,
  output logic                    done_o,
  output mascon_pkg::mascon_out_t res_o
);
  import mascon_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e            state_q, state_d;
  mascon_st_t        st_q, st_d;
  logic [RoundW-1:0] round_q, round_d;
  logic              done_q, done_d;
  mascon_out_t       res_q, res_d;
  logic              accept;

  assign accept = start && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    round_d = round_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          st_d.a  = {in_i.share_a_word4, in_i.share_a_word3, in_i.share_a_word2,
                     in_i.share_a_word1, in_i.share_a_word0};
          st_d.b  = {in_i.share_b_word4, in_i.share_b_word3, in_i.share_b_word2,
                     in_i.share_b_word1, in_i.share_b_word0};
          st_d.t  = in_i.random_mask;
          round_d = in_i.start_round;
          state_d = StRun;
        end
      end
      StRun: begin
        if (round_q >= LastRound) begin
          res_d.out_a_word0 = st_q.a[0];
          res_d.out_a_word1 = st_q.a[1];
          res_d.out_a_word2 = st_q.a[2];
          res_d.out_a_word3 = st_q.a[3];
          res_d.out_a_word4 = st_q.a[4];
          res_d.out_b_word0 = st_q.b[0];
          res_d.out_b_word1 = st_q.b[1];
          res_d.out_b_word2 = st_q.b[2];
          res_d.out_b_word3 = st_q.b[3];
          res_d.out_b_word4 = st_q.b[4];
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          st_d    = mascon_round(st_q, round_q);
          round_d = round_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      st_q    <= st_d;
      round_q <= round_d;
      res_q   <= res_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/mascon_checker.sv]
// port-level checker for the masked ascon permutation, bound to the top level
module mascon_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input mascon_pkg::mascon_in_t in_i,
  input logic                   done_o
);
  import mascon_pkg::*;

  // result strobe only comes once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("done while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // every finished permutation ends with exactly one strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // no rounds to run: the loaded state is registered as the result without any round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start && !busy && (in_i.start_round >= LastRound)) |=> ##1 done_o)
    else $error("pass-through word not returned promptly");

endmodule

bind masked_ascon_permutation mascon_checker u_mascon_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .in_i   (in_i),
  .done_o (done_o)
);

[tb/tb_masked_ascon_permutation.sv]
// self-checking testbench for the two-share masked ascon permutation
module tb_masked_ascon_permutation;
  import mascon_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned CalmTail = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  mascon_in_t  in_i = '0;
  logic        done_o;
  mascon_out_t res_o;

  mascon_in_t  pending_words[$];
  mascon_out_t expected_shares[$];

  int unsigned n_words = 0;
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned n_checked = 0;
  int unsigned n_bypass = 0;
  int unsigned n_full = 0;
  int unsigned n_fail = 0;
  int unsigned idle_left = 0;
  int unsigned stall_cnt = 0;

  masked_ascon_permutation u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic word_t ror64(word_t v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // rounds start_round..11 on both shares, mask chain carried across rounds
  function automatic mascon_out_t permute_shares(mascon_in_t w);
    word_t       a[5];
    word_t       b[5];
    word_t       na[5];
    word_t       nb[5];
    word_t       mask_a;
    word_t       mask_b;
    int          r;
    int          i;
    int          j;
    int          k;
    mascon_out_t o;
    a[0] = w.share_a_word0; a[1] = w.share_a_word1; a[2] = w.share_a_word2;
    a[3] = w.share_a_word3; a[4] = w.share_a_word4;
    b[0] = w.share_b_word0; b[1] = w.share_b_word1; b[2] = w.share_b_word2;
    b[3] = w.share_b_word3; b[4] = w.share_b_word4;
    mask_a = w.random_mask;
    for (r = int'(w.start_round); r < int'(NumRounds); r++) begin
      // round constant goes into share a only
      a[2] = a[2] ^ {56'd0, RcBase - 4'(r), 4'(r)};
      a[0] = a[0] ^ a[4]; a[4] = a[4] ^ a[3]; a[2] = a[2] ^ a[1];
      b[0] = b[0] ^ b[4]; b[4] = b[4] ^ b[3]; b[2] = b[2] ^ b[1];
      mask_b = mask_a ^ (b[0] & b[1]) ^ (b[0] & a[1]);
      mask_a = mask_a ^ (~a[0] & b[1]) ^ (~a[0] & a[1]);
      for (i = 0; i < 4; i++) begin
        j = i + 1;
        k = (i + 2) % 5;
        na[i] = a[i] ^ (~a[j] & b[k]) ^ (~a[j] & a[k]);
        nb[i] = b[i] ^ (b[j] & b[k]) ^ (b[j] & a[k]);
      end
      na[4] = a[4] ^ mask_a;
      nb[4] = b[4] ^ mask_b;
      na[1] = na[1] ^ na[0]; na[0] = na[0] ^ na[4]; na[3] = na[3] ^ na[2];
      na[2] = ~na[2];
      nb[1] = nb[1] ^ nb[0]; nb[0] = nb[0] ^ nb[4]; nb[3] = nb[3] ^ nb[2];
      a[0] = na[0] ^ ror64(na[0], 19) ^ ror64(na[0], 28);
      a[1] = na[1] ^ ror64(na[1], 61) ^ ror64(na[1], 39);
      a[2] = na[2] ^ ror64(na[2], 1)  ^ ror64(na[2], 6);
      a[3] = na[3] ^ ror64(na[3], 10) ^ ror64(na[3], 17);
      a[4] = na[4] ^ ror64(na[4], 7)  ^ ror64(na[4], 41);
      b[0] = nb[0] ^ ror64(nb[0], 19) ^ ror64(nb[0], 28);
      b[1] = nb[1] ^ ror64(nb[1], 61) ^ ror64(nb[1], 39);
      b[2] = nb[2] ^ ror64(nb[2], 1)  ^ ror64(nb[2], 6);
      b[3] = nb[3] ^ ror64(nb[3], 10) ^ ror64(nb[3], 17);
      b[4] = nb[4] ^ ror64(nb[4], 7)  ^ ror64(nb[4], 41);
    end
    o.out_a_word0 = a[0]; o.out_a_word1 = a[1]; o.out_a_word2 = a[2];
    o.out_a_word3 = a[3]; o.out_a_word4 = a[4];
    o.out_b_word0 = b[0]; o.out_b_word1 = b[1]; o.out_b_word2 = b[2];
    o.out_b_word3 = b[3]; o.out_b_word4 = b[4];
    return o;
  endfunction

  // mostly dense random data, sometimes all zeros or all ones
  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic mascon_in_t rand_perm_word(logic [RoundW-1:0] rnd_from);
    mascon_in_t w;
    w.share_a_word0 = rand_word(); w.share_a_word1 = rand_word();
    w.share_a_word2 = rand_word(); w.share_a_word3 = rand_word();
    w.share_a_word4 = rand_word();
    w.share_b_word0 = rand_word(); w.share_b_word1 = rand_word();
    w.share_b_word2 = rand_word(); w.share_b_word3 = rand_word();
    w.share_b_word4 = rand_word();
    w.start_round   = rnd_from;
    w.random_mask   = rand_word();
    return w;
  endfunction

  function automatic void add_word(mascon_in_t w);
    pending_words.push_back(w);
    if (w.start_round >= LastRound) n_bypass++;
    if (w.start_round == '0) n_full++;
  endfunction

  // stimulus
  initial begin
    mascon_in_t w;
    int         s;
    // every start round, including the pass-through values twelve and above
    for (s = 0; s < 16; s++) add_word(rand_perm_word(RoundW'(s)));
    // extremes of the shares and of the mask
    w = '0;
    add_word(w);
    w = '1;
    w.start_round = '0;
    add_word(w);
    w = rand_perm_word('0);
    {w.share_b_word0, w.share_b_word1, w.share_b_word2, w.share_b_word3,
     w.share_b_word4} = '0;
    w.random_mask = '1;
    add_word(w);
    w = rand_perm_word('0);
    {w.share_a_word0, w.share_a_word1, w.share_a_word2, w.share_a_word3,
     w.share_a_word4} = '0;
    w.random_mask = '0;
    add_word(w);
    w = '1;
    w.start_round = 4'd11;
    add_word(w);
    for (s = 0; s < int'(RandomWords); s++) begin
      if ($urandom_range(0, 31) == 0) add_word(rand_perm_word(RoundW'($urandom_range(13, 15))));
      else add_word(rand_perm_word(RoundW'($urandom_range(0, 12))));
    end
    n_words = pending_words.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_taken == n_words && n_checked == n_words);
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_shares.size() != 0) begin
      $error("%0d expected results never arrived", expected_shares.size());
      n_fail++;
    end
    $display("ran %0d permutation words: %0d from round 0, %0d pass-through starts",
             n_words, n_full, n_bypass);
    $display("compared %0d results share by share with %0d mismatching", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver: present a new word only once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni && n_taken == n_sent) begin
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_words.size() > 0) begin
        in_i <= pending_words.pop_front();
        start <= 1'b1;
        n_sent <= n_sent + 1;
        if (n_sent + CalmTail < n_words && $urandom_range(0, 3) == 0) begin
          idle_left <= $urandom_range(1, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results first, since a result in the same cycle belongs to an older word
  always @(posedge clk_i) begin
    mascon_out_t exp_res;
    word_t [9:0] exp_w;
    word_t [9:0] got_w;
    int          i;
    if (rst_ni) begin
      if (done_o) begin
        n_checked <= n_checked + 1;
        if (expected_shares.size() == 0) begin
          $error("result with no word outstanding");
          n_fail = n_fail + 1;
        end else begin
          exp_res = expected_shares.pop_front();
          exp_w = exp_res;
          got_w = res_o;
          for (i = 0; i < 10; i++) begin
            if (exp_w[9-i] !== got_w[9-i]) begin
              $error("out_%s_word%0d: expected %h, got %h", (i < 5) ? "a" : "b", i % 5,
                     exp_w[9-i], got_w[9-i]);
              n_fail = n_fail + 1;
            end
          end
        end
      end
      if (start && !busy) begin
        expected_shares.push_back(permute_shares(in_i));
        n_taken <= n_taken + 1;
      end
      if (done_o || (start && !busy)) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= StallLimit) begin
        $display("no progress for %0d cycles", StallLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

endmodule
